// ===== src/handle_id_allocator_top_assert.svh =====
// Assertion macros for the handle id allocator.
// Used by handle_id_allocator_top.sv; expects clk and arst_n in scope.
`ifndef HANDLE_ID_ALLOCATOR_TOP_ASSERT_SVH
`define HANDLE_ID_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define HIA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("handle id allocator: property violated");
// condition must never be seen at a clock edge out of reset
`define HIA_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("handle id allocator: forbidden condition");
`else
`define HIA_ASSERT(lbl, prop)
`define HIA_NEVER(lbl, cond)
`endif
`endif

// ===== src/hia_pkg.sv =====
// Package for the handle id allocator: sizes, codes and the table entry type.
// No dependencies; used by handle_id_allocator_top.sv.
package hia_pkg;

	// table geometry
	localparam int DEPTH        = 4096;
	localparam int HANDLE_WIDTH = 32;
	localparam int ADDR_W       = $clog2(DEPTH);
	localparam int CNT_W        = ADDR_W + 1;

	// fixed field widths
	localparam int REG_W        = 13;
	localparam int ID_W         = 12;
	localparam int OUT_HANDLE_W = 32;
	localparam int OP_W         = 2;
	localparam int STAT_W       = 2;
	localparam int CFG_IDX_W    = 1;

	// compare width wide enough for counts, registers and ids
	localparam int CMP_W  = (CNT_W > REG_W) ? CNT_W : REG_W;
	localparam int GROW_W = CMP_W + 1;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	// operation codes
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	// configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY_LIMIT = 1'b1;
	localparam logic [REG_W-1:0]     CHUNK_SIZE_RST     = 13'd256;
	localparam logic [REG_W-1:0]     CAPACITY_LIMIT_RST = 13'd4096;

	// one table word: occupied flag and stored handle
	typedef struct packed {
		logic                    valid;
		logic [HANDLE_WIDTH-1:0] handle;
	} entry_t;

endpackage

// ===== src/hia_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hia_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== src/handle_id_allocator_top.sv =====
// Handle id allocator top level: sequencer around one table RAM.
// Depends on hia_pkg, hia_ram and handle_id_allocator_top_assert.svh.

// Hands out small ids for object handles, stack-like. An allocation at the
// top mark, and any word answered from the registers alone (out-of-range
// lookup or release, unused code), is finished in the idle state; a lookup,
// or a release that is not of the topmost entry, waits for the registered
// read of the table RAM. Releasing the topmost entry then walks the top mark
// down over empty entries to an occupied one, or down to id 0. Once growth
// has stopped, an allocation scans from id 0 with one RAM read and one check
// per entry, until it finds a free entry or finds all entries below the top
// mark taken. One word is worked on at a time; a finished result waits in
// the output register while the next word is accepted. No clearing pass
// runs after reset: every entry below the top mark has been written since
// reset, and entries at or above it are never read as occupied.
`include "handle_id_allocator_top_assert.svh"

module handle_id_allocator_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// configuration write port
	input  logic                                    cfg_wr_en,
	input  logic [hia_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [hia_pkg::REG_W-1:0]               cfg_wdata,
	// request channel
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [hia_pkg::OP_W-1:0]                operation,
	input  logic [hia_pkg::HANDLE_WIDTH-1:0]        handle,
	input  logic [hia_pkg::ID_W-1:0]                entry_id,
	// result channel
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [hia_pkg::ID_W-1:0]                result_id,
	output logic [hia_pkg::OUT_HANDLE_W-1:0]        result_handle,
	output logic [hia_pkg::STAT_W-1:0]              status
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SHR_RD,
		ST_SHR_CHK,
		ST_SRCH_RD,
		ST_SRCH_CHK,
		ST_HOLD
	} state_t;

	state_t state_q, state_d;

	// configuration
	logic [hia_pkg::REG_W-1:0] chunk_q, cap_q;

	// table bookkeeping
	logic [hia_pkg::CNT_W-1:0] top_q, top_d;
	logic [hia_pkg::CNT_W-1:0] alloc_q, alloc_d;
	logic [hia_pkg::CNT_W-1:0] idx_q, idx_d;

	// captured request
	logic [hia_pkg::OP_W-1:0]         op_q, op_d;
	logic [hia_pkg::ID_W-1:0]         id_q, id_d;
	logic [hia_pkg::HANDLE_WIDTH-1:0] hdl_q, hdl_d;

	// result waiting for the output register
	logic [hia_pkg::ID_W-1:0]         pend_id_q, pend_id_d;
	logic [hia_pkg::OUT_HANDLE_W-1:0] pend_handle_q, pend_handle_d;
	logic [hia_pkg::STAT_W-1:0]       pend_status_q, pend_status_d;

	// output register
	logic                             out_valid_q, out_valid_d;
	logic [hia_pkg::ID_W-1:0]         out_id_q, out_id_d;
	logic [hia_pkg::OUT_HANDLE_W-1:0] out_handle_q, out_handle_d;
	logic [hia_pkg::STAT_W-1:0]       out_status_q, out_status_d;

	// result finished this cycle
	logic                             fin_valid;
	logic [hia_pkg::ID_W-1:0]         fin_id;
	logic [hia_pkg::OUT_HANDLE_W-1:0] fin_handle;
	logic [hia_pkg::STAT_W-1:0]       fin_status;

	// table RAM
	logic                       ram_we;
	logic [hia_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
	hia_pkg::entry_t            ram_wdata, ram_rdata;

	logic out_free;

	// shared compare and growth arithmetic
	logic [hia_pkg::CMP_W-1:0]  id_ext, top_ext, alloc_ext, cap_ext, step_ext;
	logic [hia_pkg::GROW_W-1:0] grown;
	logic [hia_pkg::CNT_W-1:0]  alloc_grown, top_m1;
	logic                       id_in_range, need_grow, grow_stop, top_full, id_is_top;

	hia_ram #(
		.WIDTH ($bits(hia_pkg::entry_t)),
		.DEPTH (hia_pkg::DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign result_id     = out_id_q;
	assign result_handle = out_handle_q;
	assign status        = out_status_q;
	assign out_free      = !out_valid_q || !out_stall;

	// range checks and chunk growth
	assign id_ext      = hia_pkg::CMP_W'(entry_id);
	assign top_ext     = hia_pkg::CMP_W'(top_q);
	assign alloc_ext   = hia_pkg::CMP_W'(alloc_q);
	assign cap_ext     = hia_pkg::CMP_W'(cap_q);
	assign step_ext    = (chunk_q == '0) ? hia_pkg::CMP_W'(1) : hia_pkg::CMP_W'(chunk_q);
	assign grown       = {1'b0, alloc_ext} + {1'b0, step_ext};
	assign alloc_grown = (grown > hia_pkg::GROW_W'(hia_pkg::DEPTH)) ?
		hia_pkg::DEPTH_CNT : hia_pkg::CNT_W'(grown);
	assign id_in_range = (id_ext < top_ext);
	assign need_grow   = (top_q >= alloc_q);
	assign grow_stop   = (alloc_ext >= cap_ext) || (alloc_q >= hia_pkg::DEPTH_CNT);
	assign top_full    = (top_q >= hia_pkg::DEPTH_CNT);
	assign id_is_top   = ((hia_pkg::CMP_W'(id_q) + hia_pkg::CMP_W'(1)) == top_ext);
	assign top_m1      = top_q - hia_pkg::CNT_W'(1);

	// sequencer next state and table access
	always_comb begin
		state_d       = state_q;
		top_d         = top_q;
		alloc_d       = alloc_q;
		idx_d         = idx_q;
		op_d          = op_q;
		id_d          = id_q;
		hdl_d         = hdl_q;
		pend_id_d     = pend_id_q;
		pend_handle_d = pend_handle_q;
		pend_status_d = pend_status_q;
		ram_we        = 1'b0;
		ram_waddr     = top_q[hia_pkg::ADDR_W-1:0];
		ram_wdata     = '{valid: 1'b1, handle: hdl_q};
		ram_raddr     = hia_pkg::ADDR_W'(entry_id);
		fin_valid     = 1'b0;
		fin_id        = '0;
		fin_handle    = '0;
		fin_status    = hia_pkg::STAT_OK;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_d  = operation;
					id_d  = entry_id;
					hdl_d = handle;
					unique case (operation)
						hia_pkg::OP_ALLOC: begin
							if (need_grow && grow_stop) begin
								// growth over: scan for a free entry
								idx_d   = '0;
								state_d = ST_SRCH_RD;
							end else begin
								if (need_grow) begin
									alloc_d = alloc_grown;
								end
								fin_valid = 1'b1;
								if (top_full) begin
									fin_status = hia_pkg::STAT_FULL;
								end else begin
									// push at the top mark
									ram_we    = 1'b1;
									ram_waddr = top_q[hia_pkg::ADDR_W-1:0];
									ram_wdata = '{valid: 1'b1, handle: handle};
									fin_id    = hia_pkg::ID_W'(top_q);
									top_d     = top_q + hia_pkg::CNT_W'(1);
								end
							end
						end
						hia_pkg::OP_LOOKUP, hia_pkg::OP_RELEASE: begin
							if (id_in_range) begin
								state_d = ST_LOOK;
							end else begin
								fin_valid  = 1'b1;
								fin_id     = entry_id;
								fin_status = hia_pkg::STAT_EMPTY;
							end
						end
						default: begin
							fin_valid  = 1'b1;
							fin_id     = entry_id;
							fin_status = hia_pkg::STAT_EMPTY;
						end
					endcase
				end
			end
			ST_LOOK: begin
				if (!ram_rdata.valid) begin
					fin_valid  = 1'b1;
					fin_id     = id_q;
					fin_status = hia_pkg::STAT_EMPTY;
				end else if (op_q == hia_pkg::OP_LOOKUP) begin
					fin_valid  = 1'b1;
					fin_id     = id_q;
					fin_handle = hia_pkg::OUT_HANDLE_W'(ram_rdata.handle);
				end else begin
					// release: clear the entry
					ram_we    = 1'b1;
					ram_waddr = hia_pkg::ADDR_W'(id_q);
					ram_wdata = '{valid: 1'b0, handle: ram_rdata.handle};
					if (id_is_top) begin
						// topmost entry: drop the top and walk down
						top_d         = hia_pkg::CNT_W'(id_q);
						pend_id_d     = id_q;
						pend_handle_d = '0;
						pend_status_d = hia_pkg::STAT_OK;
						state_d       = ST_SHR_RD;
					end else begin
						fin_valid = 1'b1;
						fin_id    = id_q;
					end
				end
			end
			ST_SHR_RD: begin
				if (top_q == '0) begin
					state_d = ST_HOLD;
				end else begin
					ram_raddr = top_m1[hia_pkg::ADDR_W-1:0];
					state_d   = ST_SHR_CHK;
				end
			end
			ST_SHR_CHK: begin
				if (ram_rdata.valid) begin
					state_d = ST_HOLD;
				end else begin
					top_d   = top_m1;
					state_d = ST_SHR_RD;
				end
			end
			ST_SRCH_RD: begin
				if (idx_q >= top_q) begin
					fin_valid  = 1'b1;
					fin_status = hia_pkg::STAT_FULL;
				end else begin
					ram_raddr = idx_q[hia_pkg::ADDR_W-1:0];
					state_d   = ST_SRCH_CHK;
				end
			end
			ST_SRCH_CHK: begin
				if (!ram_rdata.valid) begin
					ram_we    = 1'b1;
					ram_waddr = idx_q[hia_pkg::ADDR_W-1:0];
					ram_wdata = '{valid: 1'b1, handle: hdl_q};
					fin_valid = 1'b1;
					fin_id    = hia_pkg::ID_W'(idx_q);
				end else begin
					idx_d   = idx_q + hia_pkg::CNT_W'(1);
					state_d = ST_SRCH_RD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// finished word: straight to the output or park it
		if (fin_valid) begin
			if (out_free) begin
				state_d = ST_IDLE;
			end else begin
				pend_id_d     = fin_id;
				pend_handle_d = fin_handle;
				pend_status_d = fin_status;
				state_d       = ST_HOLD;
			end
		end
	end

	// output register load and drain
	always_comb begin
		out_valid_d  = out_valid_q;
		out_id_d     = out_id_q;
		out_handle_d = out_handle_q;
		out_status_d = out_status_q;
		if (fin_valid && out_free) begin
			out_valid_d  = 1'b1;
			out_id_d     = fin_id;
			out_handle_d = fin_handle;
			out_status_d = fin_status;
		end else if ((state_q == ST_HOLD) && out_free) begin
			out_valid_d  = 1'b1;
			out_id_d     = pend_id_q;
			out_handle_d = pend_handle_q;
			out_status_d = pend_status_q;
		end else if (!out_stall) begin
			out_valid_d = 1'b0;
		end
	end

	// state, bookkeeping, configuration and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			chunk_q       <= hia_pkg::CHUNK_SIZE_RST;
			cap_q         <= hia_pkg::CAPACITY_LIMIT_RST;
			top_q         <= '0;
			alloc_q       <= '0;
			idx_q         <= '0;
			op_q          <= '0;
			id_q          <= '0;
			hdl_q         <= '0;
			pend_id_q     <= '0;
			pend_handle_q <= '0;
			pend_status_q <= '0;
			out_valid_q   <= 1'b0;
			out_id_q      <= '0;
			out_handle_q  <= '0;
			out_status_q  <= '0;
		end else begin
			state_q       <= state_d;
			top_q         <= top_d;
			alloc_q       <= alloc_d;
			idx_q         <= idx_d;
			op_q          <= op_d;
			id_q          <= id_d;
			hdl_q         <= hdl_d;
			pend_id_q     <= pend_id_d;
			pend_handle_q <= pend_handle_d;
			pend_status_q <= pend_status_d;
			out_valid_q   <= out_valid_d;
			out_id_q      <= out_id_d;
			out_handle_q  <= out_handle_d;
			out_status_q  <= out_status_d;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					hia_pkg::CFG_CHUNK_SIZE:     chunk_q <= cfg_wdata;
					hia_pkg::CFG_CAPACITY_LIMIT: cap_q   <= cfg_wdata;
				endcase
			end
		end
	end

	// checks on the bookkeeping
	`HIA_ASSERT(a_top_within_alloc, top_q <= alloc_q)
	`HIA_ASSERT(a_alloc_within_depth, alloc_q <= hia_pkg::DEPTH_CNT)
	`HIA_ASSERT(a_scan_below_top, (state_q == ST_SRCH_CHK) |-> (idx_q < top_q))
	`HIA_ASSERT(a_growth_only_on_accept, (state_q != ST_IDLE) |=> $stable(alloc_q))
	`HIA_NEVER(a_full_has_zero_id,
		out_valid_q && (out_status_q == hia_pkg::STAT_FULL) && (out_id_q != '0))

endmodule

// ===== tb/sv/hia_checker.sv =====
// Checker for the handle id allocator: keeps its own copy of the id table,
// predicts each result word and compares it with what the block returns.
// Depends on hia_pkg; instantiated by tb_top beside the block.
module hia_checker
	import hia_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [REG_W-1:0]         cfg_wdata,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [OP_W-1:0]          operation,
	input  logic [HANDLE_WIDTH-1:0]  handle,
	input  logic [ID_W-1:0]          entry_id,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [ID_W-1:0]          result_id,
	input  logic [OUT_HANDLE_W-1:0]  result_handle,
	input  logic [STAT_W-1:0]        status,
	output int                       mismatches,
	output int                       outstanding
);

	typedef struct packed {
		logic [ID_W-1:0]         id;
		logic [OUT_HANDLE_W-1:0] hdl;
		logic [STAT_W-1:0]       stat;
	} reply_t;

	// mirrored table state and register copies
	logic                    occupied      [DEPTH];
	logic [HANDLE_WIDTH-1:0] stored_handle [DEPTH];
	logic [CNT_W-1:0]        top_id;
	logic [CNT_W-1:0]        region_size;
	logic [REG_W-1:0]        grow_step;
	logic [REG_W-1:0]        grow_limit;

	reply_t expected_replies [$];
	reply_t want;
	reply_t seen;

	initial mismatches = 0;

	function automatic reply_t make_reply(input logic [ID_W-1:0] id,
			input logic [OUT_HANDLE_W-1:0] hdl, input logic [STAT_W-1:0] stat);
		reply_t r;
		r.id   = id;
		r.hdl  = hdl;
		r.stat = stat;
		return r;
	endfunction

	// allocation: at the top mark, growing the region, or by search from id 0
	function automatic reply_t allocate_id(input logic [HANDLE_WIDTH-1:0] h);
		logic [GROW_W-1:0] step;
		logic [GROW_W-1:0] grown;
		reply_t            r;
		int                i;
		r = make_reply('0, '0, STAT_FULL);
		if (top_id >= region_size) begin
			if (region_size >= grow_limit || region_size >= DEPTH_CNT) begin
				for (i = 0; i < DEPTH; i++) begin
					if (i < top_id && !occupied[i] && r.stat == STAT_FULL) begin
						occupied[i]      = 1'b1;
						stored_handle[i] = h;
						r = make_reply(ID_W'(i), '0, STAT_OK);
					end
				end
				return r;
			end else begin
				// zero step counts as one; growth saturates at the table depth
				step  = (grow_step == '0) ? GROW_W'(1) : GROW_W'(grow_step);
				grown = GROW_W'(region_size) + step;
				region_size = (grown > GROW_W'(DEPTH)) ? DEPTH_CNT : CNT_W'(grown);
			end
		end
		if (top_id >= DEPTH_CNT)
			return r;
		occupied[top_id]      = 1'b1;
		stored_handle[top_id] = h;
		r = make_reply(ID_W'(top_id), '0, STAT_OK);
		top_id = top_id + 1'b1;
		return r;
	endfunction

	function automatic reply_t lookup_id(input logic [ID_W-1:0] id);
		if (CNT_W'(id) < top_id && occupied[id])
			return make_reply(id, OUT_HANDLE_W'(stored_handle[id]), STAT_OK);
		return make_reply(id, '0, STAT_EMPTY);
	endfunction

	// release; freeing the topmost entry walks the top mark down past holes
	function automatic reply_t release_id(input logic [ID_W-1:0] id);
		if (CNT_W'(id) >= top_id || !occupied[id])
			return make_reply(id, '0, STAT_EMPTY);
		occupied[id] = 1'b0;
		if (CNT_W'(id) + 1'b1 == top_id) begin
			while (top_id != '0 && !occupied[top_id - 1'b1])
				top_id = top_id - 1'b1;
		end
		return make_reply(id, '0, STAT_OK);
	endfunction

	function automatic reply_t answer_request(input logic [OP_W-1:0] op,
			input logic [HANDLE_WIDTH-1:0] h, input logic [ID_W-1:0] id);
		case (op)
			OP_ALLOC:   return allocate_id(h);
			OP_LOOKUP:  return lookup_id(id);
			OP_RELEASE: return release_id(id);
			default:    return make_reply(id, '0, STAT_EMPTY);
		endcase
	endfunction

	// result compare first, so a word accepted this edge is never matched early
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				occupied[i]      = 1'b0;
				stored_handle[i] = '0;
			end
			top_id      = '0;
			region_size = '0;
			grow_step   = CHUNK_SIZE_RST;
			grow_limit  = CAPACITY_LIMIT_RST;
			expected_replies.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = make_reply(result_id, result_handle, status);
				if (expected_replies.size() == 0) begin
					$display("%0t: unexpected result word: id %0d handle %h status %0d",
						$time, seen.id, seen.hdl, seen.stat);
					mismatches++;
				end else begin
					want = expected_replies.pop_front();
					if (seen.id !== want.id)
						$display("%0t: result_id expected %0d got %0d",
							$time, want.id, seen.id);
					if (seen.hdl !== want.hdl)
						$display("%0t: result_handle expected %h got %h",
							$time, want.hdl, seen.hdl);
					if (seen.stat !== want.stat)
						$display("%0t: status expected %0d got %0d",
							$time, want.stat, seen.stat);
					if (seen !== want)
						mismatches++;
				end
			end
			if (cfg_wr_en) begin
				if (cfg_index == CFG_CHUNK_SIZE)
					grow_step = cfg_wdata;
				else if (cfg_index == CFG_CAPACITY_LIMIT)
					grow_limit = cfg_wdata;
			end
			if (in_valid && !in_stall)
				expected_replies.push_back(answer_request(operation, handle, entry_id));
			outstanding <= expected_replies.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the handle id allocator: clock, reset, request and
// result traffic, register settings and the final verdict.
// Depends on hia_pkg, handle_id_allocator_top and hia_checker.
module tb_top;
	import hia_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 16;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_WORDS    = 36;
	localparam int FILL_WORDS     = 64;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [REG_W-1:0]        cfg_wdata;
	logic                    in_valid;
	logic                    in_stall;
	logic [OP_W-1:0]         operation;
	logic [HANDLE_WIDTH-1:0] handle;
	logic [ID_W-1:0]         entry_id;
	logic                    out_valid;
	logic                    out_stall;
	logic [ID_W-1:0]         result_id;
	logic [OUT_HANDLE_W-1:0] result_handle;
	logic [STAT_W-1:0]       status;
	int                      mismatches;
	int                      outstanding;

	bit idle_on;
	bit squeeze;
	int words_sent;
	int settings_used;
	int id_span;
	int limits [RANDOM_PHASES] = '{1, 8, 4, 16, 24, 12, 32, 40};

	handle_id_allocator_top dut (.*);
	hia_checker chk (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mostly short pauses, now and then a long one
	function automatic int pause_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// offer one word and hold it until accepted; valid stays high afterwards
	task automatic send_word(input logic [OP_W-1:0] op,
			input logic [HANDLE_WIDTH-1:0] h, input logic [ID_W-1:0] id);
		int gap;
		gap = (idle_on && $urandom_range(0, 1) == 0) ? pause_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		handle    <= h;
		entry_id  <= id;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	// drop valid and wait until every predicted result has come back
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_registers(input logic [REG_W-1:0] chunk,
			input logic [REG_W-1:0] limit);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_CHUNK_SIZE;
		cfg_wdata <= chunk;
		@(posedge clk);
		cfg_index <= CFG_CAPACITY_LIMIT;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	task automatic send_random_word();
		logic [OP_W-1:0]         op;
		logic [HANDLE_WIDTH-1:0] h;
		logic [ID_W-1:0]         id;
		int                      pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			op = OP_ALLOC;
		else if (pick < 65)
			op = OP_LOOKUP;
		else if (pick < 95)
			op = OP_RELEASE;
		else
			op = OP_UNUSED;
		pick = $urandom_range(0, 9);
		h = (pick == 0) ? '0 : (pick == 1) ? '1 : HANDLE_WIDTH'($urandom);
		// ids mostly near the live region, some anywhere in the id space
		if ($urandom_range(0, 99) < 85)
			id = ID_W'($urandom_range(0, id_span));
		else
			id = ID_W'($urandom);
		send_word(op, h, id);
	endtask

	// result side: random stalls, plus one long squeeze on request
	initial begin
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (squeeze) begin
				out_stall <= 1'b1;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
				squeeze = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat (pause_len()) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d result words still due", outstanding);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_CHUNK_SIZE;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		operation <= OP_ALLOC;
		handle    <= '0;
		entry_id  <= '0;
		idle_on = 1'b0;
		squeeze = 1'b0;
		words_sent = 0;
		settings_used = 0;
		id_span = 63;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// growth disabled on an empty table: allocation reports full
		set_registers(CHUNK_SIZE_RST, 13'd0);
		send_word(OP_ALLOC, 32'h1234_5678, '0);
		send_word(OP_LOOKUP, '0, '0);
		send_word(OP_RELEASE, '0, '0);
		send_word(OP_UNUSED, '0, 12'hFFF);
		quiesce();

		// zero chunk grows one entry at a time up to a limit of three
		set_registers(13'd0, 13'd3);
		send_word(OP_ALLOC, 32'h0000_0000, '0);
		send_word(OP_ALLOC, 32'hFFFF_FFFF, '0);
		send_word(OP_ALLOC, 32'hA5A5_5A5A, '0);
		send_word(OP_ALLOC, 32'h0BAD_F00D, '0);
		send_word(OP_LOOKUP, '0, 12'd0);
		send_word(OP_LOOKUP, '0, 12'd1);
		send_word(OP_LOOKUP, '0, 12'd2);
		send_word(OP_LOOKUP, '0, 12'd3);
		send_word(OP_LOOKUP, '0, 12'hFFF);
		send_word(OP_RELEASE, '0, 12'd1);
		send_word(OP_LOOKUP, '0, 12'd1);
		send_word(OP_RELEASE, '0, 12'd1);
		send_word(OP_ALLOC, 32'h0F0F_F0F0, '0);
		send_word(OP_RELEASE, '0, 12'd0);
		send_word(OP_RELEASE, '0, 12'd1);
		send_word(OP_RELEASE, '0, 12'd2);
		send_word(OP_LOOKUP, '0, 12'd2);
		send_word(OP_RELEASE, '0, 12'hFFF);
		send_word(OP_ALLOC, 32'h8000_0001, '0);
		send_word(OP_UNUSED, 32'hFFFF_FFFF, 12'd0);

		// small tables under random traffic, one phase squeezed at the output
		id_span = 48;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			quiesce();
			set_registers(REG_W'($urandom_range(1, 8)), REG_W'(limits[p]));
			idle_on = (p != 1);
			if (p == 3)
				squeeze = 1'b1;
			repeat (PHASE_WORDS) send_random_word();
		end

		// empty the small table from the top down
		for (int i = 63; i >= 0; i--)
			send_word(OP_RELEASE, '0, ID_W'(i));
		quiesce();

		// oversized chunk: one growth step saturates at the depth
		set_registers(13'd8191, 13'd8191);
		idle_on = 1'b0;
		repeat (FILL_WORDS) send_word(OP_ALLOC, HANDLE_WIDTH'($urandom), '0);
		send_word(OP_LOOKUP, '0, 12'hFFF);
		send_word(OP_LOOKUP, '0, 12'd0);
		send_word(OP_RELEASE, '0, ID_W'(FILL_WORDS / 2));
		send_word(OP_ALLOC, 32'hDEAD_0800, '0);
		send_word(OP_LOOKUP, '0, ID_W'(FILL_WORDS));

		// drain: top drops by one, then one long walk back to zero
		idle_on = 1'b1;
		send_word(OP_RELEASE, '0, ID_W'(FILL_WORDS));
		for (int i = 0; i < FILL_WORDS; i++)
			send_word(OP_RELEASE, '0, ID_W'(i));
		send_word(OP_LOOKUP, '0, 12'd0);
		quiesce();

		set_registers(13'd8191, 13'd4096);
		send_word(OP_ALLOC, 32'h0000_0001, '0);
		send_word(OP_LOOKUP, '0, 12'd0);
		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run summary: %0d request words over %0d register settings",
			words_sent, settings_used);
		$display("run summary: small tables with output squeeze, then %0d-entry fill and drain",
			FILL_WORDS);
		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
